/* rtl/vcd_pkg.sv */
package vcd_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned ValueWidth   = 64;
   localparam int unsigned CeilWidth    = 17;
   localparam int unsigned CountWidth   = 25;
   localparam int unsigned SeptetWidth  = 4;
   localparam int unsigned ShiftWidth   = 7;
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [CeilWidth-1:0]  CeilReset  = 17'h10000;
   localparam logic [CountWidth-1:0] CountReset = 25'd1;

   typedef enum logic [1:0] {
      ST_VALUE     = 2'd0,
      ST_OVERLONG  = 2'd1,
      ST_CEILING   = 2'd2,
      ST_TRUNCATED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_MODE    = 2'd0,
      REG_CEILING = 2'd1,
      REG_COUNT   = 2'd2,
      REG_NONE    = 2'd3
   } reg_index_type;

   typedef enum logic {
      MODE_DELTA = 1'b0,
      MODE_PLAIN = 1'b1
   } mode_type;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      status_type            status;
      logic                  is_last;
   } rsp_item_type;

   typedef struct packed {
      logic         first_valid;
      rsp_item_type first;
      logic         second_valid;
      rsp_item_type second;
   } rsp_pair_type;

endpackage

/* rtl/varint_column_decoder_unit.sv */
// LEB128 column decoder. Bytes of one column section enter on the req channel,
// one transaction per byte, with section_end marking the last byte. Decoded
// values and error reports leave on the rsp channel, one transaction each.
// The user must set column mode, value ceiling and value count through the
// APB port only while the block is idle; the block does not enforce this. A
// write takes effect from the next byte. A byte is held in an input register,
// decoded from it combinationally, and its results are loaded into a two-entry
// result register. One byte per cycle is sustained while the receiver does
// not stall; a byte that yields a value and also ends a section early holds
// off the next byte until its truncation report has been taken.
// When the receiver stalls, results stay in the result register and the req
// channel stalls in turn once the input register is full.
// After the final value or an error, further bytes are accepted and dropped.
// Reset clears the decode state, empties both registers and restores the
// configuration registers to their defaults.
module varint_column_decoder_unit import vcd_pkg::*; #(
   parameter int MAX_SEPTETS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [ByteWidth-1:0]    req_data_byte,
   input  logic                    req_section_end,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [ValueWidth-1:0] rsp_value,
   output logic [1:0]              rsp_status,
   output logic                    rsp_is_last,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   mode_type              mode_ff;
   logic [CeilWidth-1:0]  ceiling_ff;
   logic [CountWidth-1:0] count_ff;
   reg_index_type         reg_index;
   logic                  csr_write;

   logic                  in_valid_ff;
   logic [ByteWidth-1:0]  in_byte_ff;
   logic                  in_end_ff;
   logic                  free_next;
   logic                  fire;
   rsp_pair_type          pair;
   rsp_item_type          rsp_item;

   assign pready = 1'b1;
   assign reg_index = reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      unique case (reg_index)
         REG_MODE:    prdata = CsrDataWidth'(mode_ff);
         REG_CEILING: prdata = CsrDataWidth'(ceiling_ff);
         REG_COUNT:   prdata = CsrDataWidth'(count_ff);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DELTA;
         ceiling_ff <= CeilReset;
         count_ff <= CountReset;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_MODE:    mode_ff <= mode_type'(pwdata[0]);
            REG_CEILING: ceiling_ff <= pwdata[CeilWidth-1:0];
            REG_COUNT:   count_ff <= pwdata[CountWidth-1:0];
            default:     ;
         endcase
      end
   end

   assign fire = in_valid_ff && free_next;
   assign req_stall = in_valid_ff && !free_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_end_ff <= req_section_end;
      end
   end

   vcd_decode #(
      .MAX_SEPTETS(MAX_SEPTETS)
   ) u_decode (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .data_byte(in_byte_ff),
      .section_end(in_end_ff),
      .column_mode(mode_ff),
      .value_ceiling(ceiling_ff),
      .value_count(count_ff),
      .pair(pair)
   );

   vcd_out u_out (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .pair(pair),
      .free_next(free_next),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   assign rsp_value = $signed(rsp_item.value);
   assign rsp_status = rsp_item.status;
   assign rsp_is_last = rsp_item.is_last;

endmodule

/* rtl/vcd_decode.sv */
module vcd_decode import vcd_pkg::*; #(
   parameter int MAX_SEPTETS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [ByteWidth-1:0]  data_byte,
   input  logic                  section_end,
   input  mode_type              column_mode,
   input  logic [CeilWidth-1:0]  value_ceiling,
   input  logic [CountWidth-1:0] value_count,
   output rsp_pair_type          pair
);

   logic [ValueWidth-1:0]  partial_ff, partial_in;
   logic [SeptetWidth-1:0] septet_ff, septet_in;
   logic [ValueWidth-1:0]  sum_ff, sum_in;
   logic [CountWidth-1:0]  done_ff, done_in;
   logic                   halted_ff, halted_in;

   logic [ShiftWidth-1:0]  shift;
   logic [ValueWidth-1:0]  merged;
   logic [ValueWidth-1:0]  delta;
   logic [ValueWidth-1:0]  sum_next;
   logic [CountWidth-1:0]  done_next;
   logic                   count_hit;
   logic [SeptetWidth-1:0] septet_next;
   logic                   have_first;
   logic                   halt_first;
   rsp_item_type           first_item;
   rsp_item_type           trunc_item;

   always_comb begin
      shift = ShiftWidth'({septet_ff, 3'b000}) - ShiftWidth'(septet_ff);
      merged = partial_ff;
      if (shift < ShiftWidth'(ValueWidth)) begin
         merged = partial_ff | (ValueWidth'(data_byte[6:0]) << shift);
      end
      delta = {1'b0, merged[ValueWidth-1:1]} ^ {ValueWidth{merged[0]}};
      sum_next = sum_ff + delta;
      done_next = done_ff + CountWidth'(1);
      count_hit = (done_next == value_count);
      septet_next = septet_ff + SeptetWidth'(1);

      partial_in = partial_ff;
      septet_in = septet_ff;
      sum_in = sum_ff;
      done_in = done_ff;
      have_first = 1'b0;
      halt_first = 1'b0;
      first_item = '{value: '0, status: ST_VALUE, is_last: 1'b0};
      trunc_item = '{value: '0, status: ST_TRUNCATED, is_last: 1'b1};

      if (!data_byte[7]) begin
         partial_in = '0;
         septet_in = '0;
         have_first = 1'b1;
         if (column_mode == MODE_DELTA) begin
            sum_in = sum_next;
            done_in = done_next;
            halt_first = count_hit;
            first_item = '{value: sum_next, status: ST_VALUE, is_last: count_hit};
         end else if (merged >= ValueWidth'(value_ceiling)) begin
            halt_first = 1'b1;
            first_item = '{value: '0, status: ST_CEILING, is_last: 1'b1};
         end else begin
            done_in = done_next;
            halt_first = count_hit;
            first_item = '{value: merged, status: ST_VALUE, is_last: count_hit};
         end
      end else begin
         partial_in = merged;
         septet_in = septet_next;
         if (septet_next >= SeptetWidth'(MAX_SEPTETS)) begin
            have_first = 1'b1;
            halt_first = 1'b1;
            first_item = '{value: '0, status: ST_OVERLONG, is_last: 1'b1};
         end
      end

      halted_in = halt_first || section_end;

      pair.first_valid = 1'b0;
      pair.first = first_item;
      pair.second_valid = 1'b0;
      pair.second = trunc_item;
      if (!halted_ff) begin
         if (have_first) begin
            pair.first_valid = 1'b1;
            pair.second_valid = section_end && !halt_first;
         end else if (section_end) begin
            pair.first_valid = 1'b1;
            pair.first = trunc_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         septet_ff <= '0;
         sum_ff <= '0;
         done_ff <= '0;
         halted_ff <= 1'b0;
      end else if (fire && !halted_ff) begin
         partial_ff <= partial_in;
         septet_ff <= septet_in;
         sum_ff <= sum_in;
         done_ff <= done_in;
         halted_ff <= halted_in;
      end
   end

endmodule

/* rtl/vcd_out.sv */
module vcd_out import vcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  rsp_pair_type pair,
   output logic         free_next,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         first_valid_ff, first_valid_in;
   logic         second_valid_ff, second_valid_in;
   rsp_item_type first_ff, second_ff;
   logic         pop;

   always_comb begin
      rsp_valid = first_valid_ff || second_valid_ff;
      rsp_item = first_valid_ff ? first_ff : second_ff;
      pop = rsp_valid && !rsp_stall;
      first_valid_in = first_valid_ff && !pop;
      second_valid_in = second_valid_ff && !(pop && !first_valid_ff);
      free_next = !first_valid_in && !second_valid_in;
      if (fire) begin
         first_valid_in = pair.first_valid;
         second_valid_in = pair.second_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_valid_ff <= 1'b0;
         second_valid_ff <= 1'b0;
      end else begin
         first_valid_ff <= first_valid_in;
         second_valid_ff <= second_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         first_ff <= pair.first;
         second_ff <= pair.second;
      end
   end

endmodule

/* dv/varint_column_decoder_unit_tb.sv */
`timescale 1ns / 1ps

module varint_column_decoder_unit_tb;
   import vcd_pkg::*;

   localparam int MaxSeptets  = 10;
   localparam int CycleLimit  = 500000;
   localparam int RandomItems = 1900;
   localparam int HoldCycles  = 300;

   class column_decode_tracker;
      mode_type             mode;
      logic [CeilWidth-1:0]  ceiling;
      logic [CountWidth-1:0] count;
      logic [63:0]           partial;
      logic [3:0]            septets;
      logic [63:0]           running_sum;
      logic [CountWidth-1:0] values_done;
      logic                  halted;
      rsp_item_type          pending[$];
      int                    failures;

      function new();
         mode        = MODE_DELTA;
         ceiling     = CeilReset;
         count       = CountReset;
         partial     = '0;
         septets     = '0;
         running_sum = '0;
         values_done = '0;
         halted      = 1'b0;
         failures    = 0;
      endfunction

      function void set_register(reg_index_type idx, logic [31:0] data);
         case (idx)
            REG_MODE: begin
               mode = mode_type'(data[0]);
            end
            REG_CEILING: begin
               ceiling = data[CeilWidth-1:0];
            end
            REG_COUNT: begin
               count = data[CountWidth-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function void add_result(logic [63:0] v, status_type st, logic last);
         rsp_item_type r;
         r.value   = v;
         r.status  = st;
         r.is_last = last;
         pending.push_back(r);
      endfunction

      function void take_byte(logic [7:0] b, logic section_end);
         int          shift;
         logic [63:0] raw;
         logic [63:0] delta;
         if (halted) return;
         shift = 7 * septets;
         if (shift < 64) partial = partial | (64'(b[6:0]) << shift);
         if (!b[7]) begin
            raw     = partial;
            partial = '0;
            septets = '0;
            if (mode == MODE_DELTA) begin
               delta       = (raw >> 1) ^ {64{raw[0]}};
               running_sum = running_sum + delta;
               values_done = values_done + 1'b1;
               halted      = (values_done == count);
               add_result(running_sum, ST_VALUE, halted);
            end else if (raw >= {47'b0, ceiling}) begin
               halted = 1'b1;
               add_result('0, ST_CEILING, 1'b1);
            end else begin
               values_done = values_done + 1'b1;
               halted      = (values_done == count);
               add_result(raw, ST_VALUE, halted);
            end
         end else begin
            septets = septets + 1'b1;
            if (septets >= MaxSeptets) begin
               halted = 1'b1;
               add_result('0, ST_OVERLONG, 1'b1);
            end
         end
         if (section_end && !halted) begin
            halted = 1'b1;
            add_result('0, ST_TRUNCATED, 1'b1);
         end
      endfunction

      function void match_result(logic [63:0] v, logic [1:0] st, logic last);
         rsp_item_type want;
         if (pending.size() == 0) begin
            failures++;
            $display("%0t: expected no transaction, actual value %h status %0d is_last %b",
                     $time, v, st, last);
            return;
         end
         want = pending.pop_front();
         if (v !== want.value) begin
            failures++;
            $display("%0t: value expected %h actual %h", $time, want.value, v);
         end
         if (st !== want.status) begin
            failures++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, st);
         end
         if (last !== want.is_last) begin
            failures++;
            $display("%0t: is_last expected %b actual %b", $time, want.is_last, last);
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [ByteWidth-1:0]    req_data_byte;
   logic                    req_section_end;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [ValueWidth-1:0] rsp_value;
   logic [1:0]              rsp_status;
   logic                    rsp_is_last;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   column_decode_tracker tracker = new();
   int  cycles = 0;
   int  bytes_offered = 0;
   int  burst_left = 1;
   int  burst_max = 12;
   int  gap_max = 4;
   bit  hold_off_request = 1'b0;

   varint_column_decoder_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_section_end (req_section_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_status      (rsp_status),
      .rsp_is_last     (rsp_is_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("varint_column_decoder_unit: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         tracker.match_result(rsp_value, rsp_status, rsp_is_last);
      end
   end

   initial begin
      int seg;
      int pct;
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            repeat (HoldCycles) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            seg = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
               0: pct = 0;
               1: pct = 25;
               2: pct = 50;
               default: pct = 85;
            endcase
            repeat (seg) begin
               @(posedge clock);
               rsp_stall <= ($urandom_range(0, 99) < pct);
            end
         end
      end
   end

   task automatic csr_write(reg_index_type idx, logic [31:0] data);
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      pwrite  <= 1'b1;
      psel    <= 1'b1;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tracker.set_register(idx, data);
      @(posedge clock);
   endtask

   task automatic set_column(mode_type m, logic [CeilWidth-1:0] ceil,
                             logic [CountWidth-1:0] cnt);
      csr_write(REG_MODE, {31'b0, m});
      csr_write(REG_CEILING, {15'b0, ceil});
      csr_write(REG_COUNT, {7'b0, cnt});
   endtask

   task automatic offer_byte(logic [7:0] b, logic section_end);
      int gap;
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_section_end <= section_end;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.take_byte(b, section_end);
      bytes_offered++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, burst_max);
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_varint(logic [63:0] v, int pad, logic end_last);
      int         len;
      int         i;
      logic [7:0] b;
      len = 1;
      while (len < MaxSeptets && (v >> (7 * len)) != 0) len++;
      len = len + pad;
      if (len > MaxSeptets) len = MaxSeptets;
      for (i = 0; i < len; i++) begin
         b[6:0] = (7 * i < 64) ? 7'(v >> (7 * i)) : 7'd0;
         b[7]   = (i != len - 1);
         offer_byte(b, end_last && (i == len - 1));
      end
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [CountWidth-1:0] safe_count(logic [CountWidth-1:0] cand);
      logic [CountWidth-1:0] ahead;
      ahead = cand - tracker.values_done;
      if (ahead >= 1 && ahead <= 4000) return '0;
      return cand;
   endfunction

   function automatic logic [63:0] random_raw();
      case ($urandom_range(0, 4))
         0: return 64'($urandom_range(0, 255));
         1: return {$urandom, $urandom};
         2: return 64'($urandom_range(0, 65535));
         3: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
         default: return 64'd1 << $urandom_range(0, 63);
      endcase
   endfunction

   function automatic int random_pad();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0;
   endfunction

   task automatic run_random_phase(int n);
      int                    stop_at;
      int                    k;
      logic [7:0]            b;
      logic [CeilWidth-1:0]  ceil;
      logic [CountWidth-1:0] cnt;
      mode_type              m;
      m = mode_type'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: ceil = 17'd1;
         1: ceil = 17'h10000;
         2: ceil = 17'($urandom_range(1, 65536));
         default: ceil = 17'($urandom_range(1, 300));
      endcase
      case ($urandom_range(0, 3))
         0: cnt = 25'd1;
         1: cnt = 25'd16777216;
         2: cnt = '0;
         default: cnt = 25'($urandom_range(1, 16777216));
      endcase
      set_column(m, ceil, safe_count(cnt));
      stop_at = bytes_offered + n;
      while (bytes_offered < stop_at) begin
         if (m == MODE_DELTA && $urandom_range(0, 4) == 0) begin
            k = $urandom_range(1, 4);
            repeat (k) begin
               b = 8'($urandom_range(0, 255));
               if (tracker.septets >= MaxSeptets - 1) b[7] = 1'b0;
               offer_byte(b, 1'b0);
            end
         end else if (m == MODE_DELTA) begin
            send_varint(random_raw(), random_pad(), 1'b0);
         end else begin
            case ($urandom_range(0, 3))
               0: send_varint(64'(ceil) - 1, random_pad(), 1'b0);
               1: send_varint('0, random_pad(), 1'b0);
               default: send_varint(64'($urandom_range(0, ceil - 1)), random_pad(), 1'b0);
            endcase
         end
      end
      if (tracker.septets != 0) offer_byte(8'($urandom_range(0, 127)), 1'b0);
      wait_quiet();
   endtask

   task automatic run_closing_sequence();
      int                    k;
      int                    i;
      logic [CeilWidth-1:0]  ceil;
      logic [CountWidth-1:0] cnt;
      logic [63:0]           v;
      case ($urandom_range(0, 5))
         0: begin
            k = $urandom_range(1, 3);
            cnt = tracker.values_done + 25'(k);
            set_column(MODE_DELTA, CeilReset, cnt);
            repeat (k) send_varint(random_raw(), random_pad(), 1'b0);
         end
         1: begin
            ceil = ($urandom_range(0, 3) == 0) ? '0 : 17'($urandom_range(1, 65536));
            set_column(MODE_PLAIN, ceil, safe_count('0));
            v = ($urandom_range(0, 1) == 0) ? 64'(ceil) + 64'($urandom_range(0, 500))
                                            : {1'b1, 31'($urandom), $urandom};
            send_varint(v, random_pad(), 1'b0);
         end
         2: begin
            set_column(MODE_DELTA, CeilReset, safe_count('0));
            repeat (MaxSeptets) offer_byte(8'($urandom_range(128, 255)), 1'b0);
         end
         3: begin
            set_column(MODE_DELTA, CeilReset, safe_count('0));
            k = $urandom_range(1, MaxSeptets - 1);
            for (i = 0; i < k; i++) begin
               offer_byte(8'($urandom_range(128, 255)), i == k - 1);
            end
         end
         4: begin
            set_column(MODE_DELTA, CeilReset, safe_count('0));
            send_varint(random_raw(), random_pad(), 1'b1);
         end
         default: begin
            cnt = tracker.values_done + 25'd1;
            set_column(MODE_DELTA, CeilReset, cnt);
            send_varint(random_raw(), random_pad(), 1'b1);
         end
      endcase
      repeat (30) offer_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int first_phase;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_data_byte   <= '0;
      req_section_end <= 1'b0;
      rsp_stall       <= 1'b0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_column(MODE_DELTA, CeilReset, '0);
      send_varint('0, 0, 1'b0);
      send_varint(64'd1, 0, 1'b0);
      send_varint(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
      repeat (MaxSeptets - 1) offer_byte(8'hFF, 1'b0);
      offer_byte(8'h7F, 1'b0);
      send_varint('0, MaxSeptets - 1, 1'b0);
      wait_quiet();

      set_column(MODE_PLAIN, 17'h10000, 25'd16777216);
      send_varint('0, 0, 1'b0);
      send_varint(64'd65535, 0, 1'b0);
      send_varint(64'd300, 3, 1'b0);
      wait_quiet();

      set_column(MODE_PLAIN, 17'd1, 25'd16777216);
      send_varint('0, 0, 1'b0);
      send_varint('0, 2, 1'b0);
      wait_quiet();

      first_phase = 1;
      while (bytes_offered < RandomItems) begin
         if (first_phase) begin
            burst_max = 64;
            gap_max = 0;
            hold_off_request = 1'b1;
            first_phase = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            burst_max = 64;
            gap_max = 0;
         end else begin
            burst_max = $urandom_range(1, 20);
            gap_max = $urandom_range(1, 8);
         end
         burst_left = 1;
         run_random_phase($urandom_range(100, 250));
      end

      run_closing_sequence();
      wait_quiet();
      if (tracker.failures == 0 && tracker.pending.size() == 0) begin
         $display("varint_column_decoder_unit: match");
      end else begin
         $display("varint_column_decoder_unit: mismatch");
      end
      $finish;
   end

endmodule

/* varint_column_decoder_unit.f */
rtl/vcd_pkg.sv
rtl/vcd_decode.sv
rtl/vcd_out.sv
rtl/varint_column_decoder_unit.sv
dv/varint_column_decoder_unit_tb.sv
